[design/gspe_pkg.sv]
// ----------------------------------------------------------------------------
// gspe_pkg: shared types and constants of the gait step period estimator
// Holds the payload structs of both channels, the field widths and the
// fixed constants of the contact and period checks.
// ----------------------------------------------------------------------------
`default_nettype none

package gspe_pkg;

	// Field widths.
	localparam int RAW_W    = 10;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 13;
	localparam int THR_W    = 13;
	localparam int AVG_W    = 17;

	// Width of a raw sample scaled by the full-scale millivolt value.
	localparam int SCALED_W = 24;

	// Scaling and range constants.
	localparam logic [SCALED_W-1:0] FULL_SCALE_MV = SCALED_W'(5000);
	localparam logic [SCALED_W-1:0] ADC_MAX       = SCALED_W'(1023);
	localparam logic [TIME_W-1:0]   PERIOD_MIN_MS = TIME_W'(155);
	localparam logic [TIME_W-1:0]   PERIOD_MAX_MS = TIME_W'(5000);

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic           REG_IDX_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2500);

	// Default depth of the period ring.
	localparam int HISTORY_DEPTH_DEF = 8;

	// Input item.
	typedef struct packed {
		logic [RAW_W-1:0]  left_raw;
		logic [RAW_W-1:0]  right_raw;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic             left_contact;
		logic             right_contact;
		logic             step_seen;
		logic             period_accepted;
		logic [AVG_W-1:0] average_period_x16;
	} out_item_t;

endpackage

`default_nettype wire

[design/gspe_ram.sv]
// ----------------------------------------------------------------------------
// gspe_ram: generic single-clock RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read request.
// ----------------------------------------------------------------------------
`default_nettype none

module gspe_ram #(
	parameter int WIDTH  = 13,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/gait_step_period_estimator.sv]
// A result passes the stage 1, stage 2 and output registers after its input transfer.
// A new item is not taken while the previous one is in stage 1; the ring
// read-modify-write of the period memory (read at transfer, write in stage 1) is why.
// A stalled result holds the input side once the pipeline behind it is full.
// Reset clears levels, rise times, ring index, sum and average at once; per-entry
// valid bits make the ring read as zero, so items are taken right after reset.
// ----------------------------------------------------------------------------
// gait_step_period_estimator: step period moving average
// Detects rising foot contact edges, measures the interval since the last
// rise of that foot (left only on a joint rise) and keeps the mean of the
// last HISTORY_DEPTH valid periods, fixed point with four fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_step_period_estimator
	import gspe_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_item,
	// Output channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_item,
	// Configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int DEPTH_LOG = $clog2(HISTORY_DEPTH);
	localparam int SUM_W     = PERIOD_W + DEPTH_LOG;
	localparam int AVG_N     = SUM_W + 4;
	localparam int AVG_SHIFT = AVG_N + DEPTH_LOG;
	localparam int RECIP_W   = AVG_SHIFT - DEPTH_LOG + 2;
	localparam longint unsigned RECIP =
		((longint'(1) << AVG_SHIFT) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
	localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(HISTORY_DEPTH * 5000);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [THR_W-1:0] threshold_q;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_write && (paddr[2] == REG_IDX_THRESHOLD)) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	// Reads return the threshold; other addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX_THRESHOLD) begin
			prdata = CFG_DATA_W'(threshold_q);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic s2_valid_q;
	logic out_valid_q;
	logic s2_move;
	logic in_xfer;

	assign s2_move  = s2_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q && (!s2_valid_q || s2_move);
	assign in_xfer  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Contact detection at the input transfer
	// ------------------------------------------------------------------
	// floor(raw * 5000 / 1023) > thr is the same as raw * 5000 >= (thr + 1) * 1023.
	logic [SCALED_W-1:0] left_scaled;
	logic [SCALED_W-1:0] right_scaled;
	logic [SCALED_W-1:0] thr_scaled;
	logic                left_new;
	logic                right_new;
	logic                left_level_q;
	logic                right_level_q;
	logic                left_rise;
	logic                right_rise;
	logic [TIME_W-1:0]   left_rise_time_q;
	logic [TIME_W-1:0]   right_rise_time_q;
	logic [TIME_W-1:0]   interval;
	logic                in_range;

	assign left_scaled  = SCALED_W'(in_item.left_raw) * FULL_SCALE_MV;
	assign right_scaled = SCALED_W'(in_item.right_raw) * FULL_SCALE_MV;
	assign thr_scaled   = (SCALED_W'(threshold_q) + SCALED_W'(1)) * ADC_MAX;
	assign left_new     = (left_scaled >= thr_scaled);
	assign right_new    = (right_scaled >= thr_scaled);
	assign left_rise    = left_new && !left_level_q;
	assign right_rise   = right_new && !right_level_q;

	// The left foot wins when both rise together.
	assign interval = left_rise ? (in_item.now_ms - left_rise_time_q)
	                            : (in_item.now_ms - right_rise_time_q);
	assign in_range = (interval >= PERIOD_MIN_MS) && (interval <= PERIOD_MAX_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_level_q      <= 1'b0;
			right_level_q     <= 1'b0;
			left_rise_time_q  <= '0;
			right_rise_time_q <= '0;
		end else if (in_xfer) begin
			left_level_q  <= left_new;
			right_level_q <= right_new;
			if (left_rise) begin
				left_rise_time_q <= in_item.now_ms;
			end else if (right_rise) begin
				right_rise_time_q <= in_item.now_ms;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 registers
	// ------------------------------------------------------------------
	logic                left_contact_s1;
	logic                right_contact_s1;
	logic                step_s1;
	logic                accept_s1;
	logic [PERIOD_W-1:0] period_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_contact_s1  <= left_new;
			right_contact_s1 <= right_new;
			step_s1          <= left_rise || right_rise;
			accept_s1        <= (left_rise || right_rise) && in_range;
			period_s1        <= interval[PERIOD_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Period ring: read the slot being replaced at transfer, write in stage 1
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]         wr_idx_q;
	logic [HISTORY_DEPTH-1:0] entry_valid_q;
	logic [PERIOD_W-1:0]      ram_rdata;
	logic [PERIOD_W-1:0]      old_period;
	logic                     ring_write;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sum_next;

	assign ring_write = s1_valid_q && accept_s1;

	gspe_ram #(
		.WIDTH  (PERIOD_W),
		.DEPTH  (HISTORY_DEPTH),
		.ADDR_W (IDX_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_write),
		.waddr (wr_idx_q),
		.wdata (period_s1),
		.re    (in_xfer),
		.raddr (wr_idx_q),
		.rdata (ram_rdata)
	);

	// A slot never written since reset counts as zero.
	assign old_period = entry_valid_q[wr_idx_q] ? ram_rdata : '0;
	assign sum_next   = sum_q - SUM_W'(old_period) + SUM_W'(period_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q      <= '0;
			entry_valid_q <= '0;
			sum_q         <= '0;
		end else if (ring_write) begin
			entry_valid_q[wr_idx_q] <= 1'b1;
			sum_q                   <= sum_next;
			if (wr_idx_q == IDX_W'(HISTORY_DEPTH - 1)) begin
				wr_idx_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: mean by reciprocal multiplication, then the output register
	// ------------------------------------------------------------------
	logic                        left_contact_s2;
	logic                        right_contact_s2;
	logic                        step_s2;
	logic                        accept_s2;
	logic [AVG_N+RECIP_W-1:0]    avg_product;
	logic [AVG_W-1:0]            avg_new;
	logic [AVG_W-1:0]            avg_q;
	out_item_t                   out_q;

	assign avg_product = (AVG_N+RECIP_W)'({sum_q, 4'b0000}) * (AVG_N+RECIP_W)'(RECIP_V);
	assign avg_new     = avg_product[AVG_SHIFT +: AVG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= s1_valid_q || (s2_valid_q && !s2_move);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			left_contact_s2  <= left_contact_s1;
			right_contact_s2 <= right_contact_s1;
			step_s2          <= step_s1;
			accept_s2        <= accept_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
			if (accept_s2) begin
				avg_q <= avg_new;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_q.left_contact       <= left_contact_s2;
			out_q.right_contact      <= right_contact_s2;
			out_q.step_seen          <= step_s2;
			out_q.period_accepted    <= accept_s2;
			out_q.average_period_x16 <= accept_s2 ? avg_new : avg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Only one item is in the ring update stage at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |=> !s1_valid_q)
		else $error("two items back to back in the ring update stage");

	// The running sum never exceeds the largest possible ring total.
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running period sum out of range");

	// The write index stays inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= IDX_W'(HISTORY_DEPTH - 1))
		else $error("ring write index beyond the ring depth");

	// A stored period always comes from a detected step.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && accept_s1 |-> step_s1)
		else $error("period stored without a step");

	// A result mean never exceeds the largest accepted period.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.average_period_x16 <= AVG_W'(80000)))
		else $error("average period out of range");

endmodule

`default_nettype wire

[tb/gait_step_period_estimator_tb.sv]
// ----------------------------------------------------------------------------
// gait_step_period_estimator_tb: self-checking bench of the step period block
// Drives pressure samples and timestamps through the valid/ready input
// channel, models contact detection, rise intervals and the period ring
// average, and compares every result transfer field by field. The contact
// threshold is swept over its range through the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_step_period_estimator_tb;
	import gspe_pkg::*;

	localparam int HIST          = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = CFG_ADDR_W'(4 * REG_IDX_THRESHOLD);

	// Clock, reset and DUT ports.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b1;
	out_item_t             out_item;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr     = '0;
	logic [CFG_DATA_W-1:0] pwdata    = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Shadow copy of the block state used to predict each result.
	logic [THR_W-1:0]    threshold_mv    = THRESHOLD_RESET;
	logic                left_level      = 1'b0;
	logic                right_level     = 1'b0;
	logic [TIME_W-1:0]   left_rise_time  = '0;
	logic [TIME_W-1:0]   right_rise_time = '0;
	logic [PERIOD_W-1:0] period_ring [HIST];
	int                  ring_idx        = 0;
	logic [AVG_W-1:0]    period_avg      = '0;

	// Results predicted for accepted input transfers, oldest first.
	out_item_t expected_steps [$];

	int          mismatch_count = 0;
	int          cycle_count    = 0;
	logic [31:0] gait_clock     = '0;

	// Idling controls for both channels.
	int burst_left = 0;
	int burst_max  = 8;
	int gap_max    = 3;
	int stall_max  = 4;
	int ready_run  = 0;

	gait_step_period_estimator #(
		.HISTORY_DEPTH(HIST)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Free-running clock, 12 time units per period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver stall pattern: ready runs alternate with stall runs.
	always @(negedge clk) begin
		if (stall_max == 0) begin
			out_ready <= 1'b1;
		end else if (ready_run > 0) begin
			ready_run--;
		end else begin
			out_ready <= !out_ready;
			ready_run = out_ready ? $urandom_range(0, stall_max - 1) : $urandom_range(0, 15);
		end
	end

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_steps.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, out_item);
				mismatch_count++;
			end else begin
				want = expected_steps.pop_front();
				report_field("left_contact", 32'(want.left_contact),
					32'(out_item.left_contact));
				report_field("right_contact", 32'(want.right_contact),
					32'(out_item.right_contact));
				report_field("step_seen", 32'(want.step_seen), 32'(out_item.step_seen));
				report_field("period_accepted", 32'(want.period_accepted),
					32'(out_item.period_accepted));
				report_field("average_period_x16", 32'(want.average_period_x16),
					32'(out_item.average_period_x16));
			end
		end
	end

	function automatic logic [THR_W-1:0] raw_to_mv(logic [RAW_W-1:0] raw);
		logic [SCALED_W-1:0] scaled;
		scaled = SCALED_W'(raw) * FULL_SCALE_MV;
		return THR_W'(scaled / ADC_MAX);
	endfunction

	// Advance the shadow state by one item and return the result it causes.
	function automatic out_item_t predict_step(in_item_t it);
		out_item_t         res;
		logic              lnew;
		logic              rnew;
		logic              lrise;
		logic              rrise;
		logic [TIME_W-1:0] interval;
		logic [31:0]       sum;
		int                i;
		lnew  = raw_to_mv(it.left_raw) > threshold_mv;
		rnew  = raw_to_mv(it.right_raw) > threshold_mv;
		lrise = lnew && !left_level;
		rrise = rnew && !right_level;
		left_level  = lnew;
		right_level = rnew;
		res.period_accepted = 1'b0;
		if (lrise || rrise) begin
			// A joint rise measures the left foot only.
			if (lrise) begin
				interval       = it.now_ms - left_rise_time;
				left_rise_time = it.now_ms;
			end else begin
				interval        = it.now_ms - right_rise_time;
				right_rise_time = it.now_ms;
			end
			if (interval >= PERIOD_MIN_MS && interval <= PERIOD_MAX_MS) begin
				period_ring[ring_idx] = interval[PERIOD_W-1:0];
				ring_idx = (ring_idx == HIST - 1) ? 0 : ring_idx + 1;
				sum = 0;
				for (i = 0; i < HIST; i++)
					sum += 32'(period_ring[i]);
				period_avg = AVG_W'((sum * 16) / HIST);
				res.period_accepted = 1'b1;
			end
		end
		res.left_contact       = lnew;
		res.right_contact      = rnew;
		res.step_seen          = lrise || rrise;
		res.average_period_x16 = period_avg;
		return res;
	endfunction

	function automatic in_item_t make_item(logic [RAW_W-1:0] l, logic [RAW_W-1:0] r,
		logic [TIME_W-1:0] now);
		in_item_t it;
		it.left_raw  = l;
		it.right_raw = r;
		it.now_ms    = now;
		return it;
	endfunction

	// Random sample on the wanted side of the threshold, with a fallback.
	function automatic logic [RAW_W-1:0] pick_raw(logic want_contact);
		logic [RAW_W-1:0] r;
		int               k;
		for (k = 0; k < 64; k++) begin
			r = RAW_W'($urandom_range(0, 1023));
			if ((raw_to_mv(r) > threshold_mv) == want_contact)
				return r;
		end
		return want_contact ? RAW_W'(1023) : RAW_W'(0);
	endfunction

	// Step period, mostly in range with the range edges favored.
	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)  return 32'd155;
		if (r < 10) return 32'd5000;
		if (r < 13) return 32'd154;
		if (r < 16) return 32'd5001;
		if (r < 22) return $urandom_range(1, 154);
		if (r < 28) return $urandom_range(5001, 40000);
		return $urandom_range(155, 5000);
	endfunction

	// Send one item in bursts; record its prediction at the transfer edge.
	task automatic send_step(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		expected_steps.push_back(predict_step(it));
		burst_left--;
	endtask

	// Stop sending and let every predicted result arrive.
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == THRESHOLD_ADDR)
			threshold_mv = data[THR_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic cfg_read_check(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		report_field("threshold readback", 32'(want), 32'(prdata[THR_W-1:0]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic shuffle_idling(bit quiet);
		if (quiet) begin
			gap_max   = 0;
			stall_max = 0;
		end else begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_max = $urandom_range(1, 16);
	endtask

	// Walking sequences with noise mixed in, until n items are sent.
	task automatic run_gait(int n_items);
		int          sent;
		logic [31:0] p;
		bit          joint;
		sent = 0;
		if ($urandom_range(0, 3) == 0)
			gait_clock = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		else
			gait_clock = $urandom;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 12) begin
				// Noise: arbitrary samples and timestamp.
				send_step(make_item(RAW_W'($urandom), RAW_W'($urandom),
					($urandom_range(0, 1) == 1) ? $urandom : gait_clock + $urandom_range(0, 300)));
				sent++;
			end else begin
				// One gait cycle: left rise, hold, swing, right rise, swing.
				p     = pick_period();
				joint = ($urandom_range(0, 9) == 0);
				send_step(make_item(pick_raw(1'b1), pick_raw(joint), gait_clock));
				send_step(make_item(pick_raw(1'b1), pick_raw(1'b0), gait_clock + p / 8));
				send_step(make_item(pick_raw(1'b0), pick_raw(1'b0), gait_clock + p / 4));
				send_step(make_item(pick_raw(1'b0), pick_raw(1'b1), gait_clock + p / 2));
				send_step(make_item(pick_raw(1'b0), pick_raw(1'b0), gait_clock + 3 * p / 4));
				gait_clock += p;
				sent += 5;
			end
			if ($urandom_range(0, 19) == 0)
				shuffle_idling($urandom_range(0, 4) == 0);
			// Occasionally hold off until the block has drained.
			if ($urandom_range(0, 29) == 0)
				settle_idle();
		end
	endtask

	task automatic test_reset_threshold();
		cfg_read_check(THRESHOLD_ADDR, THRESHOLD_RESET);
	endtask

	task automatic test_directed_edges();
		// Nothing in contact, at timestamp zero.
		send_step(make_item(10'd0, 10'd0, 32'd0));
		// First rise after reset measures from zero.
		send_step(make_item(10'd1023, 10'd0, 32'd1000));
		send_step(make_item(10'd0, 10'd0, 32'd1100));
		// Shortest interval that is kept.
		send_step(make_item(10'd1023, 10'd0, 32'd1155));
		// Just below and just above the default threshold.
		send_step(make_item(10'd511, 10'd0, 32'd1200));
		send_step(make_item(10'd512, 10'd0, 32'd1309));
		send_step(make_item(10'd0, 10'd0, 32'd1400));
		// Longest interval that is kept, then one too long.
		send_step(make_item(10'd512, 10'd0, 32'd6309));
		send_step(make_item(10'd0, 10'd0, 32'd6400));
		send_step(make_item(10'd1023, 10'd0, 32'd11310));
		send_step(make_item(10'd0, 10'd0, 32'd11400));
		// Both feet rise together: only the left foot is measured.
		send_step(make_item(10'd1023, 10'd1023, 32'd12000));
		send_step(make_item(10'd0, 10'd0, 32'd12100));
		send_step(make_item(10'd0, 10'd1023, 32'd12500));
		send_step(make_item(10'd0, 10'd0, 32'd12700));
		send_step(make_item(10'd0, 10'd1023, 32'd13000));
		// Interval across the timestamp wrap.
		send_step(make_item(10'd0, 10'd0, 32'hFFFF_FF00));
		send_step(make_item(10'd1023, 10'd0, 32'hFFFF_FF00));
		send_step(make_item(10'd0, 10'd0, 32'hFFFF_FFFF));
		send_step(make_item(10'd1023, 10'd0, 32'h0000_0100));
		// Left held, right rises with an out-of-range interval.
		send_step(make_item(10'd1023, 10'd1023, 32'hFFFF_FFFF));
		send_step(make_item(10'd0, 10'd0, 32'd0));
	endtask

	task automatic test_walking_default();
		shuffle_idling(1'b0);
		run_gait(560);
	endtask

	task automatic test_threshold_sweep();
		logic [THR_W-1:0] levels [6];
		int               k;
		levels = '{THR_W'(0), THR_W'(5000), THR_W'(4999), THR_W'(1),
			THR_W'($urandom_range(0, 5000)), THR_W'($urandom_range(0, 5000))};
		for (k = 0; k < 6; k++) begin
			settle_idle();
			cfg_write(THRESHOLD_ADDR, CFG_DATA_W'(levels[k]));
			cfg_read_check(THRESHOLD_ADDR, levels[k]);
			shuffle_idling(1'b0);
			run_gait(120);
		end
	endtask

	task automatic test_back_to_back();
		settle_idle();
		cfg_write(THRESHOLD_ADDR, CFG_DATA_W'(THRESHOLD_RESET));
		cfg_read_check(THRESHOLD_ADDR, THRESHOLD_RESET);
		shuffle_idling(1'b1);
		run_gait(150);
	endtask

	initial begin
		for (int i = 0; i < HIST; i++)
			period_ring[i] = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_threshold();
		test_directed_edges();
		test_walking_default();
		test_threshold_sweep();
		test_back_to_back();

		settle_idle();
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
design/gspe_pkg.sv
design/gspe_ram.sv
design/gait_step_period_estimator.sv
tb/gait_step_period_estimator_tb.sv
